// ===== rtl/sorted_priority_queue_core_macros.svh =====
// Assertion macros shared by the priority queue RTL.
// Each macro samples on clock and is disabled while reset is high.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication.
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("priority queue check failed");

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("priority queue check failed");

`endif

// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int FILL_W   = $clog2(CAPACITY + 1);

   // Command codes
   localparam logic [1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [1:0] CMD_PEEK    = 2'd2;
   // Spare encoding: accepted, leaves the queue alone, answers all zero
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   // Status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] item_value;
      logic signed [31:0] item_priority;
   } spq_req_type;

   typedef struct packed {
      logic signed [31:0] out_item;
      logic signed [31:0] out_priority;
      logic [1:0]         status;
   } spq_rsp_type;

   typedef struct packed {
      logic signed [31:0] item;
      logic signed [31:0] prio;
   } spq_entry_type;

   // Broadcast to every cell of the chain
   typedef struct packed {
      logic          enq;
      logic          deq;
      spq_entry_type ins;
   } spq_ctrl_type;

endpackage

// ===== rtl/spq_cell.sv =====
`timescale 1ns / 1ps
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  spq_ctrl_type  ctrl_i,
   input  logic          is_head_i,
   input  logic          valid_i,
   input  logic          left_gt_i,
   input  spq_entry_type left_entry_i,
   input  spq_entry_type right_entry_i,
   output logic          gt_o,
   output spq_entry_type entry_o
);

   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   // Flag whether this slot stays ahead of the new entry
   always_comb begin
      if (is_head_i) begin
         gt_o = valid_i & !($signed(ctrl_i.ins.prio) > $signed(entry_ff.prio));
      end else begin
         gt_o = valid_i & ($signed(entry_ff.prio) > $signed(ctrl_i.ins.prio));
      end
   end

   // Hold, take the new entry, shift down on insert or shift up on removal
   always_comb begin
      entry_in = entry_ff;
      if (ctrl_i.enq) begin
         if (!gt_o) begin
            entry_in = left_gt_i ? ctrl_i.ins : left_entry_i;
         end
      end else if (ctrl_i.deq) begin
         entry_in = right_entry_i;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_o = entry_ff;

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Payload        Handshake
// req_      in         spq_req_type   req_valid / req_ready
// rsp_      out        spq_rsp_type   rsp_valid / rsp_ready
//
// In the cell chain all slots compare against the new priority in parallel
// and shift in the same edge. The result appears in the output register the
// cycle after acceptance.
// Synchronous reset empties the queue; slot contents are not cleared.
// A result waiting on rsp_ready stalls new requests only when it is not taken
// in the same cycle.
module sorted_priority_queue_core
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  spq_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output spq_rsp_type rsp_data
);

`include "sorted_priority_queue_core_macros.svh"

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              rsp_valid_ff, rsp_valid_in;
   spq_rsp_type       rsp_ff, rsp_in;

   logic                  accept;
   logic                  full, empty;
   spq_ctrl_type          ctrl;
   logic [CAPACITY-1:0]   valid;
   logic [CAPACITY-1:0]   gt;
   spq_entry_type         ent [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (fill_ff == FILL_W'(CAPACITY));
   assign empty     = (fill_ff == '0);

   // Broadcast control to the chain
   always_comb begin
      ctrl.enq       = accept && (req_data.cmd == CMD_ENQUEUE) && !full;
      ctrl.deq       = accept && (req_data.cmd == CMD_DEQUEUE) && !empty;
      ctrl.ins.item  = req_data.item_value;
      ctrl.ins.prio  = req_data.item_priority;
   end

   // Build the chain of slots
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic          left_gt;
      spq_entry_type left_entry;
      spq_entry_type right_entry;

      assign valid[k] = (fill_ff > FILL_W'(k));

      if (k == 0) begin : g_first
         assign left_gt    = 1'b1;
         assign left_entry = '0;
      end else begin : g_rest
         assign left_gt    = gt[k-1];
         assign left_entry = ent[k-1];
      end

      if (k == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = ent[k+1];
      end

      spq_cell u_cell (
         .clock         (clock),
         .ctrl_i        (ctrl),
         .is_head_i     (k == 0),
         .valid_i       (valid[k]),
         .left_gt_i     (left_gt),
         .left_entry_i  (left_entry),
         .right_entry_i (right_entry),
         .gt_o          (gt[k]),
         .entry_o       (ent[k])
      );
   end

   // Advance the fill count
   always_comb begin
      fill_in = fill_ff;
      if (ctrl.enq) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctrl.deq) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   // Form the result from the head slot
   always_comb begin
      rsp_in = '0;
      case (req_data.cmd)
         CMD_ENQUEUE: begin
            if (full) begin
               rsp_in.status = STATUS_FULL;
            end
         end
         CMD_DEQUEUE: begin
            if (empty) begin
               rsp_in.status = STATUS_UNDERFLOW;
            end else begin
               rsp_in.out_item     = ent[0].item;
               rsp_in.out_priority = ent[0].prio;
            end
         end
         CMD_PEEK: begin
            if (empty) begin
               rsp_in.status = STATUS_UNDERFLOW;
            end else begin
               rsp_in.out_item = ent[0].item;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // Hold the result until it is taken
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SPQ_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= FILL_W'(CAPACITY))
   `SPQ_ASSERT_NEXT(a_enq_grows, ctrl.enq, fill_ff == $past(fill_ff) + 1'b1)
   `SPQ_ASSERT_NEXT(a_deq_shrinks, ctrl.deq, fill_ff == $past(fill_ff) - 1'b1)
   `SPQ_ASSERT_NEXT(a_rsp_follows, accept, rsp_valid_ff)
   `SPQ_ASSERT_NOW(a_head_order, valid[1], $signed(ent[0].prio) >= $signed(ent[1].prio))

endmodule
